/* design/fltpu_pkg.sv */
// Shared constants, codes and types of the four-level page-table updater.
`default_nettype none
package fltpu_pkg;

  localparam int POOL_FRAMES   = 16;
  localparam int TABLE_ENTRIES = 512;

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int FRAME_W = 40;
  localparam int VP_W    = 36;
  localparam int ENTRY_W = 64;
  localparam int PAGE_W  = 12;

  // Frames in use count 0..POOL_FRAMES; table index 0 is the root table,
  // pool frame n is table index n + 1.
  localparam int FIU_W     = $clog2(POOL_FRAMES + 1);
  localparam int TBL_W     = FIU_W;
  localparam int ADDR_W    = TBL_W + IDX_W;
  localparam int MEM_DEPTH = (POOL_FRAMES + 1) * TABLE_ENTRIES;

  localparam logic [TBL_W-1:0]  ROOT_TBL  = '0;
  localparam logic [PAGE_W-1:0] LINK_BITS = 12'h003;

  localparam logic [1:0] CMD_MAP       = 2'd0;
  localparam logic [1:0] CMD_UNMAP     = 2'd1;
  localparam logic [1:0] CMD_SET_FLAGS = 2'd2;
  localparam logic [1:0] CMD_NOP       = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
  localparam logic [1:0] ST_POOL_EMPTY = 2'd2;

  localparam logic [1:0] LVL_LEAF = 2'd3;

  // Datapath operations issued by the controller, one per cycle.
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE      = 4'd0;
  localparam op_t OP_LOAD      = 4'd1;
  localparam op_t OP_READ      = 4'd2;
  localparam op_t OP_CHECK     = 4'd3;
  localparam op_t OP_FOLLOW    = 4'd4;
  localparam op_t OP_LINK      = 4'd5;
  localparam op_t OP_ZERO      = 4'd6;
  localparam op_t OP_CLEAR     = 4'd7;
  localparam op_t OP_LEAF_MAP  = 4'd8;
  localparam op_t OP_LEAF_UNMAP = 4'd9;
  localparam op_t OP_LEAF_SET  = 4'd10;
  localparam op_t OP_FAIL_NM   = 4'd11;
  localparam op_t OP_FAIL_POOL = 4'd12;
  localparam op_t OP_EMIT      = 4'd13;

  typedef struct packed {
    logic       present;
    logic       in_use;
    logic       pool_full;
    logic       leaf_lvl;
    logic       cnt_last;
    logic       out_free;
    logic [1:0] cmd;
  } dp_stat_t;

endpackage
`default_nettype wire

/* design/fltpu_dpath.sv */
// Datapath: table memory, walk registers, frame allocator and result register.
`default_nettype none
module fltpu_dpath (
  input  wire                           clk,
  input  wire                           rst_n,
  input  fltpu_pkg::op_t                op,
  output fltpu_pkg::dp_stat_t           stat,
  input  wire [1:0]                     in_command,
  input  wire [fltpu_pkg::VP_W-1:0]     in_virtual_page,
  input  wire [fltpu_pkg::FRAME_W-1:0]  in_physical_frame,
  input  wire [fltpu_pkg::ENTRY_W-1:0]  in_page_flags,
  input  wire                           cfg_valid,
  input  wire [fltpu_pkg::FRAME_W-1:0]  cfg_pool_base_frame,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [1:0]                    out_status,
  output logic [fltpu_pkg::ENTRY_W-1:0] out_leaf_entry,
  output logic [1:0]                    out_tables_created
);

  logic [fltpu_pkg::ENTRY_W-1:0] mem [fltpu_pkg::MEM_DEPTH];

  logic [fltpu_pkg::FRAME_W-1:0] base_r;
  logic [fltpu_pkg::FIU_W-1:0]   fiu_r;
  logic [1:0]                    cmd_r;
  logic [fltpu_pkg::VP_W-1:0]    vp_r;
  logic [fltpu_pkg::FRAME_W-1:0] frame_r;
  logic [fltpu_pkg::ENTRY_W-1:0] flags_r;
  logic [fltpu_pkg::TBL_W-1:0]   tbl_r;
  logic [1:0]                    lvl_r;
  logic [1:0]                    status_r;
  logic [fltpu_pkg::ENTRY_W-1:0] leaf_r;
  logic [1:0]                    created_r;
  logic [fltpu_pkg::ENTRY_W-1:0] rdata_r;
  logic [fltpu_pkg::FRAME_W-1:0] diff_r;
  logic [fltpu_pkg::FRAME_W-1:0] newfrm_r;
  logic [fltpu_pkg::IDX_W-1:0]   cnt_r;
  logic                          out_valid_r;
  logic [1:0]                    out_status_r;
  logic [fltpu_pkg::ENTRY_W-1:0] out_leaf_r;
  logic [1:0]                    out_created_r;

  logic [fltpu_pkg::IDX_W-1:0]   idx;
  logic [fltpu_pkg::ADDR_W-1:0]  walk_addr;
  logic                          we;
  logic [fltpu_pkg::ADDR_W-1:0]  waddr;
  logic [fltpu_pkg::ENTRY_W-1:0] wdata;
  logic [fltpu_pkg::ENTRY_W-1:0] leaf_map;
  logic [fltpu_pkg::ENTRY_W-1:0] leaf_set;
  logic [fltpu_pkg::FRAME_W-1:0] fiu_ext;
  logic                          out_free;

  always_comb begin
    case (lvl_r)
      2'd0:    idx = vp_r[4*fltpu_pkg::IDX_W-1:3*fltpu_pkg::IDX_W];
      2'd1:    idx = vp_r[3*fltpu_pkg::IDX_W-1:2*fltpu_pkg::IDX_W];
      2'd2:    idx = vp_r[2*fltpu_pkg::IDX_W-1:fltpu_pkg::IDX_W];
      default: idx = vp_r[fltpu_pkg::IDX_W-1:0];
    endcase
  end

  assign walk_addr = {tbl_r, idx};
  assign fiu_ext   = {{(fltpu_pkg::FRAME_W-fltpu_pkg::FIU_W){1'b0}}, fiu_r};
  assign leaf_map  = {{(fltpu_pkg::ENTRY_W-fltpu_pkg::FRAME_W-fltpu_pkg::PAGE_W){1'b0}},
                      frame_r, {fltpu_pkg::PAGE_W{1'b0}}}
                     | flags_r | fltpu_pkg::ENTRY_W'(1);
  assign leaf_set  = {rdata_r[fltpu_pkg::ENTRY_W-1:fltpu_pkg::PAGE_W],
                      {fltpu_pkg::PAGE_W{1'b0}}} | flags_r | fltpu_pkg::ENTRY_W'(1);
  assign out_free  = !out_valid_r || !out_stall;

  // Single write port shared by clearing, zeroing, linking and leaf updates.
  always_comb begin
    we    = 1'b0;
    waddr = walk_addr;
    wdata = '0;
    case (op)
      fltpu_pkg::OP_CLEAR: begin
        we    = 1'b1;
        waddr = {fltpu_pkg::ROOT_TBL, cnt_r};
      end
      fltpu_pkg::OP_ZERO: begin
        we    = 1'b1;
        waddr = {tbl_r, cnt_r};
      end
      fltpu_pkg::OP_LINK: begin
        we    = 1'b1;
        wdata = {{(fltpu_pkg::ENTRY_W-fltpu_pkg::FRAME_W-fltpu_pkg::PAGE_W){1'b0}},
                 newfrm_r, fltpu_pkg::LINK_BITS};
      end
      fltpu_pkg::OP_LEAF_MAP: begin
        we    = 1'b1;
        wdata = leaf_map;
      end
      fltpu_pkg::OP_LEAF_UNMAP: begin
        we    = 1'b1;
      end
      fltpu_pkg::OP_LEAF_SET: begin
        we    = 1'b1;
        wdata = leaf_set;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (op == fltpu_pkg::OP_READ) begin
      rdata_r <= mem[walk_addr];
    end
  end

  // Control state: configuration, allocator, sweep counter, result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      fiu_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        base_r <= cfg_pool_base_frame;
      end
      if (op == fltpu_pkg::OP_LINK) begin
        fiu_r <= fiu_r + fltpu_pkg::FIU_W'(1);
        cnt_r <= '0;
      end else if (op == fltpu_pkg::OP_CLEAR || op == fltpu_pkg::OP_ZERO) begin
        cnt_r <= cnt_r + fltpu_pkg::IDX_W'(1);
      end
      if (op == fltpu_pkg::OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Walk and result payload.
  always_ff @(posedge clk) begin
    case (op)
      fltpu_pkg::OP_LOAD: begin
        cmd_r     <= in_command;
        vp_r      <= in_virtual_page;
        frame_r   <= in_physical_frame;
        flags_r   <= in_page_flags;
        tbl_r     <= fltpu_pkg::ROOT_TBL;
        lvl_r     <= '0;
        status_r  <= fltpu_pkg::ST_OK;
        leaf_r    <= '0;
        created_r <= '0;
      end
      fltpu_pkg::OP_CHECK: begin
        diff_r   <= rdata_r[fltpu_pkg::FRAME_W+fltpu_pkg::PAGE_W-1:fltpu_pkg::PAGE_W]
                    - base_r;
        newfrm_r <= base_r + fiu_ext;
      end
      fltpu_pkg::OP_FOLLOW: begin
        tbl_r <= diff_r[fltpu_pkg::TBL_W-1:0] + fltpu_pkg::TBL_W'(1);
        lvl_r <= lvl_r + 2'd1;
      end
      fltpu_pkg::OP_LINK: begin
        tbl_r     <= fiu_r + fltpu_pkg::TBL_W'(1);
        lvl_r     <= lvl_r + 2'd1;
        created_r <= created_r + 2'd1;
      end
      fltpu_pkg::OP_LEAF_MAP: begin
        leaf_r <= leaf_map;
      end
      fltpu_pkg::OP_LEAF_SET: begin
        leaf_r <= leaf_set;
      end
      fltpu_pkg::OP_FAIL_NM: begin
        status_r <= fltpu_pkg::ST_NOT_MAPPED;
      end
      fltpu_pkg::OP_FAIL_POOL: begin
        status_r <= fltpu_pkg::ST_POOL_EMPTY;
      end
      default: begin
        cmd_r <= cmd_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (op == fltpu_pkg::OP_EMIT) begin
      out_status_r  <= status_r;
      out_leaf_r    <= leaf_r;
      out_created_r <= created_r;
    end
  end

  assign stat.present   = rdata_r[0];
  assign stat.in_use    = diff_r < fiu_ext;
  assign stat.pool_full = fiu_r >= fltpu_pkg::FIU_W'(fltpu_pkg::POOL_FRAMES);
  assign stat.leaf_lvl  = lvl_r == fltpu_pkg::LVL_LEAF;
  assign stat.cnt_last  = &cnt_r;
  assign stat.out_free  = out_free;
  assign stat.cmd       = cmd_r;

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_leaf_entry     = out_leaf_r;
  assign out_tables_created = out_created_r;

endmodule
`default_nettype wire

/* design/fltpu_ctrl.sv */
// Controller: state machine that sequences the table walk and memory sweeps.
`default_nettype none
module fltpu_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  fltpu_pkg::dp_stat_t stat,
  output fltpu_pkg::op_t      op
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_ZERO   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = fltpu_pkg::OP_NONE;
    case (state_r)
      S_CLEAR: begin
        op = fltpu_pkg::OP_CLEAR;
        if (stat.cnt_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op        = fltpu_pkg::OP_LOAD;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (stat.cmd == fltpu_pkg::CMD_NOP) begin
          state_nxt = S_DONE;
        end else begin
          op        = fltpu_pkg::OP_READ;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        op        = fltpu_pkg::OP_CHECK;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
        if (stat.leaf_lvl) begin
          if (stat.cmd == fltpu_pkg::CMD_MAP) begin
            op = fltpu_pkg::OP_LEAF_MAP;
          end else if (!stat.present) begin
            op = fltpu_pkg::OP_FAIL_NM;
          end else if (stat.cmd == fltpu_pkg::CMD_UNMAP) begin
            op = fltpu_pkg::OP_LEAF_UNMAP;
          end else begin
            op = fltpu_pkg::OP_LEAF_SET;
          end
        end else if (stat.present) begin
          if (stat.in_use) begin
            op        = fltpu_pkg::OP_FOLLOW;
            state_nxt = S_READ;
          end else begin
            op = fltpu_pkg::OP_FAIL_NM;
          end
        end else if (stat.cmd != fltpu_pkg::CMD_MAP) begin
          op = fltpu_pkg::OP_FAIL_NM;
        end else if (stat.pool_full) begin
          op = fltpu_pkg::OP_FAIL_POOL;
        end else begin
          op        = fltpu_pkg::OP_LINK;
          state_nxt = S_ZERO;
        end
      end
      S_ZERO: begin
        op = fltpu_pkg::OP_ZERO;
        if (stat.cnt_last) begin
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          op        = fltpu_pkg::OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = state_r != S_IDLE;

endmodule
`default_nettype wire

/* design/four_level_page_table_updater.sv */
// Sequence: an accepted command walks the levels with a read, a check and a decision each,
// plus a sweep that zeroes every table it creates (after its link write), then emits its result.
// Throughput: one item at a time; the next item is taken only after the result is
// registered, as the walk runs through the single-port table memory.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the root table
// while in_stall stays high. Configuration writes are taken at any time.
`default_nettype none
module four_level_page_table_updater (
  input  wire                           clk,
  input  wire                           rst_n,
  // Command channel
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire [1:0]                     in_command,
  input  wire [fltpu_pkg::VP_W-1:0]     in_virtual_page,
  input  wire [fltpu_pkg::FRAME_W-1:0]  in_physical_frame,
  input  wire [fltpu_pkg::ENTRY_W-1:0]  in_page_flags,
  // Result channel
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [1:0]                    out_status,
  output logic [fltpu_pkg::ENTRY_W-1:0] out_leaf_entry,
  output logic [1:0]                    out_tables_created,
  // Pool base register write
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [fltpu_pkg::FRAME_W-1:0]  cfg_pool_base_frame
);

  // The controller issues one datapath operation per cycle; the datapath
  // reports the walk decision inputs back as a status bundle.
  fltpu_pkg::op_t      op;
  fltpu_pkg::dp_stat_t stat;

  // A base write during a walk changes the frames that the walk checks and links;
  // writes are still accepted every cycle.
  assign cfg_ready = 1'b1;

  fltpu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .op       (op)
  );

  // Root table and pool frames share one memory: table index 0 is the root,
  // pool frame n lives at table index n + 1. Each level takes a read, a
  // register stage for the frame offset subtract, and a decision state.
  fltpu_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .op                  (op),
    .stat                (stat),
    .in_command          (in_command),
    .in_virtual_page     (in_virtual_page),
    .in_physical_frame   (in_physical_frame),
    .in_page_flags       (in_page_flags),
    .cfg_valid           (cfg_valid),
    .cfg_pool_base_frame (cfg_pool_base_frame),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_leaf_entry      (out_leaf_entry),
    .out_tables_created  (out_tables_created)
  );

endmodule
`default_nettype wire

/* design/fltpu_checker.sv */
// Port-level checker for the page-table updater and its bind.
`default_nettype none
module fltpu_checker (
  input wire                           clk,
  input wire                           rst_n,
  input wire                           in_valid,
  input wire                           in_stall,
  input wire                           out_valid,
  input wire                           out_stall,
  input wire [1:0]                     out_status,
  input wire [fltpu_pkg::ENTRY_W-1:0]  out_leaf_entry
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_leaf_entry) && $stable(out_status))
    else $error("stalled result changed");

  // One item at a time: after an accept the command channel stalls.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while another in flight");

  // A failed command reports no leaf value.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != fltpu_pkg::ST_OK |-> out_leaf_entry == '0)
    else $error("leaf value reported on failure");

  // Any written leaf carries the present bit.
  a_leaf_present: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_leaf_entry != '0 |-> out_leaf_entry[0])
    else $error("leaf value without present bit");

endmodule

bind four_level_page_table_updater fltpu_checker u_fltpu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_leaf_entry (out_leaf_entry)
);
`default_nettype wire

/* verif/pt_walk_checker.sv */
// Result checker for the four-level page-table updater: mirrors the tables and compares results.
`timescale 1ns / 1ps
module pt_walk_checker
  import fltpu_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_stall,
  input  wire [1:0]           in_command,
  input  wire [VP_W-1:0]      in_virtual_page,
  input  wire [FRAME_W-1:0]   in_physical_frame,
  input  wire [ENTRY_W-1:0]   in_page_flags,
  input  wire                 out_valid,
  input  wire                 out_stall,
  input  wire [1:0]           out_status,
  input  wire [ENTRY_W-1:0]   out_leaf_entry,
  input  wire [1:0]           out_tables_created,
  input  wire                 cfg_valid,
  input  wire                 cfg_ready,
  input  wire [FRAME_W-1:0]   cfg_pool_base_frame,
  output int                  fail_count,
  output int                  results_pending
);

  localparam logic [ENTRY_W-1:0] PRESENT_BIT = 1;

  typedef struct packed {
    logic [1:0]         status;
    logic [ENTRY_W-1:0] leaf;
    logic [1:0]         created;
  } walk_result_t;

  logic [ENTRY_W-1:0] root_tbl [TABLE_ENTRIES];
  logic [ENTRY_W-1:0] pool_tbl [POOL_FRAMES*TABLE_ENTRIES];
  int unsigned        frames_used;
  logic [FRAME_W-1:0] base_frame;
  walk_result_t       expected_walks [$];
  int                 errors;

  // Table -1 is the root; 0..POOL_FRAMES-1 are pool frames.
  function automatic logic [ENTRY_W-1:0] read_slot(int tbl, logic [IDX_W-1:0] ix);
    if (tbl < 0) return root_tbl[ix];
    return pool_tbl[tbl*TABLE_ENTRIES + ix];
  endfunction

  function automatic void write_slot(int tbl, logic [IDX_W-1:0] ix, logic [ENTRY_W-1:0] val);
    if (tbl < 0) root_tbl[ix] = val;
    else pool_tbl[tbl*TABLE_ENTRIES + ix] = val;
  endfunction

  // Pool frame that a present link points to, or -1 when it is dangling.
  function automatic int link_frame(logic [ENTRY_W-1:0] e);
    logic [FRAME_W-1:0] diff;
    diff = e[PAGE_W +: FRAME_W] - base_frame;
    if (diff >= FRAME_W'(frames_used)) return -1;
    return int'(diff);
  endfunction

  function automatic walk_result_t walk_and_update(logic [1:0] cmd, logic [VP_W-1:0] vp,
                                                   logic [FRAME_W-1:0] frame,
                                                   logic [ENTRY_W-1:0] flags);
    walk_result_t       res;
    logic [IDX_W-1:0]   ix [4];
    logic [ENTRY_W-1:0] e;
    logic [FRAME_W-1:0] link_fr;
    int                 tbl;
    int                 nxt;
    int                 lvl;
    res   = '0;
    tbl   = -1;
    ix[0] = vp[35:27];
    ix[1] = vp[26:18];
    ix[2] = vp[17:9];
    ix[3] = vp[8:0];
    if (cmd == CMD_MAP) begin
      for (lvl = 0; lvl < 3 && res.status == ST_OK; lvl++) begin
        e = read_slot(tbl, ix[lvl]);
        if (e[0]) begin
          nxt = link_frame(e);
          if (nxt < 0) res.status = ST_NOT_MAPPED;
          else tbl = nxt;
        end else if (frames_used >= POOL_FRAMES) begin
          res.status = ST_POOL_EMPTY;
        end else begin
          nxt = frames_used;
          frames_used++;
          for (int j = 0; j < TABLE_ENTRIES; j++) pool_tbl[nxt*TABLE_ENTRIES + j] = '0;
          link_fr = base_frame + FRAME_W'(nxt);
          write_slot(tbl, ix[lvl], {{(ENTRY_W-FRAME_W-PAGE_W){1'b0}}, link_fr, LINK_BITS});
          res.created = res.created + 2'd1;
          tbl = nxt;
        end
      end
      if (res.status == ST_OK) begin
        res.leaf = {{(ENTRY_W-FRAME_W-PAGE_W){1'b0}}, frame, {PAGE_W{1'b0}}}
                   | flags | PRESENT_BIT;
        write_slot(tbl, ix[3], res.leaf);
      end
    end else if (cmd == CMD_UNMAP || cmd == CMD_SET_FLAGS) begin
      for (lvl = 0; lvl < 3 && res.status == ST_OK; lvl++) begin
        e   = read_slot(tbl, ix[lvl]);
        nxt = e[0] ? link_frame(e) : -1;
        if (nxt < 0) res.status = ST_NOT_MAPPED;
        else tbl = nxt;
      end
      if (res.status == ST_OK) begin
        e = read_slot(tbl, ix[3]);
        if (!e[0]) begin
          res.status = ST_NOT_MAPPED;
        end else if (cmd == CMD_UNMAP) begin
          write_slot(tbl, ix[3], '0);
        end else begin
          res.leaf = {e[ENTRY_W-1:PAGE_W], {PAGE_W{1'b0}}} | flags | PRESENT_BIT;
          write_slot(tbl, ix[3], res.leaf);
        end
      end
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [ENTRY_W-1:0] want,
                                      logic [ENTRY_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : watch
    walk_result_t exp_res;
    if (!rst_n) begin
      foreach (root_tbl[i]) root_tbl[i] = '0;
      frames_used = 0;
      base_frame  = '0;
      expected_walks.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) base_frame = cfg_pool_base_frame;
      if (in_valid && !in_stall)
        expected_walks.push_back(walk_and_update(in_command, in_virtual_page,
                                                 in_physical_frame, in_page_flags));
      if (out_valid && !out_stall) begin
        if (expected_walks.size() == 0) begin
          $error("unexpected result: status %0d leaf %0h tables %0d",
                 out_status, out_leaf_entry, out_tables_created);
          errors++;
        end else begin
          exp_res = expected_walks.pop_front();
          check_field("status", ENTRY_W'(exp_res.status), ENTRY_W'(out_status));
          check_field("leaf_entry", exp_res.leaf, out_leaf_entry);
          check_field("tables_created", ENTRY_W'(exp_res.created),
                      ENTRY_W'(out_tables_created));
        end
      end
    end
    fail_count      <= errors;
    results_pending <= expected_walks.size();
  end

endmodule

/* verif/tb_four_level_page_table_updater.sv */
// Testbench top for the four-level page-table updater: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_four_level_page_table_updater;
  import fltpu_pkg::*;

  // Reset clearing pass, 16 table creations with their zeroing sweeps, ~620 items
  // plus heavy idling on both sides: stay well above that.
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          TAIL_CYCLES = 50;
  localparam logic [FRAME_W-1:0] FRAME_MAX = '1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_command = CMD_NOP;
  logic [VP_W-1:0]      in_virtual_page = '0;
  logic [FRAME_W-1:0]   in_physical_frame = '0;
  logic [ENTRY_W-1:0]   in_page_flags = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_status;
  logic [ENTRY_W-1:0]   out_leaf_entry;
  logic [1:0]           out_tables_created;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [FRAME_W-1:0]   cfg_pool_base_frame = '0;

  int                   fail_count;
  int                   results_pending;
  int                   tx_idle_pct = 36;
  int                   rx_idle_pct = 71;
  int                   phase = 0;
  logic                 rx_hold = 1'b0;
  int unsigned          cycle_cnt = 0;
  logic [VP_W-1:0]      mapped_pages [$];

  four_level_page_table_updater u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_virtual_page    (in_virtual_page),
    .in_physical_frame  (in_physical_frame),
    .in_page_flags      (in_page_flags),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_leaf_entry     (out_leaf_entry),
    .out_tables_created (out_tables_created),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_pool_base_frame(cfg_pool_base_frame)
  );

  pt_walk_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_virtual_page    (in_virtual_page),
    .in_physical_frame  (in_physical_frame),
    .in_page_flags      (in_page_flags),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_leaf_entry     (out_leaf_entry),
    .out_tables_created (out_tables_created),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_pool_base_frame(cfg_pool_base_frame),
    .fail_count         (fail_count),
    .results_pending    (results_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends up here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: stall at random, or hold off completely during the hold stretch.
  always @(posedge clk) begin
    out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
  end

  // Hold the result channel for a long stretch once the last phase starts, so the
  // block parks a finished result and has to stall the command side behind it.
  initial begin
    wait (phase == 2);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Pack four 9-bit table indices into a virtual page number (root index on top).
  function automatic logic [VP_W-1:0] make_vp(int i0, int i1, int i2, int i3);
    return {i0[IDX_W-1:0], i1[IDX_W-1:0], i2[IDX_W-1:0], i3[IDX_W-1:0]};
  endfunction

  task automatic set_idling(int tx_pct, int rx_pct);
    tx_idle_pct <= tx_pct;
    rx_idle_pct <= rx_pct;
  endtask

  // Offer one command item, idling first at random, and return at the accepting edge.
  // Valid stays high into the next call when no gap is drawn.
  task automatic issue_command(logic [1:0] cmd, logic [VP_W-1:0] vp,
                               logic [FRAME_W-1:0] frame, logic [ENTRY_W-1:0] flags);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_command        <= cmd;
    in_virtual_page   <= vp;
    in_physical_frame <= frame;
    in_page_flags     <= flags;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == CMD_MAP) mapped_pages.push_back(vp);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  // Write the pool base register; only called while nothing is in flight.
  task automatic write_pool_base(logic [FRAME_W-1:0] base);
    cfg_valid           <= 1'b1;
    cfg_pool_base_frame <= base;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly commands on pages already mapped (or their neighbors in the same leaf
  // table) so walks get deep; the rest land anywhere in the address space.
  task automatic send_random_commands(int count);
    logic [1:0]         cmd;
    logic [VP_W-1:0]    vp;
    logic [FRAME_W-1:0] frame;
    logic [ENTRY_W-1:0] flags;
    int                 pick;
    repeat (count) begin
      pick = $urandom_range(99);
      cmd  = (pick < 45) ? CMD_MAP : (pick < 65) ? CMD_UNMAP :
             (pick < 92) ? CMD_SET_FLAGS : CMD_NOP;
      pick = $urandom_range(99);
      if (mapped_pages.size() == 0 || pick >= 85) begin
        vp = VP_W'({$urandom, $urandom});
      end else begin
        vp = mapped_pages[$urandom_range(mapped_pages.size() - 1)];
        if (pick >= 60) vp[IDX_W-1:0] = IDX_W'($urandom);
      end
      frame = FRAME_W'({$urandom, $urandom});
      flags = {$urandom, $urandom};
      if ($urandom_range(1) == 0) flags = flags & 64'hFFF;
      issue_command(cmd, vp, frame, flags);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Top base value makes pool frame numbers wrap past zero.
    write_pool_base(FRAME_MAX);
    // Empty tables: unmap and set-flags fail at the root; the unused code does nothing.
    issue_command(CMD_UNMAP, make_vp(0, 0, 0, 0), FRAME_W'($urandom), '1);
    issue_command(CMD_SET_FLAGS, '1, '0, '1);
    issue_command(CMD_NOP, '1, FRAME_MAX, '1);
    // Fresh walks create all three intermediate tables; extremes of every field.
    issue_command(CMD_MAP, make_vp(0, 0, 0, 0), '0, '0);
    issue_command(CMD_MAP, '1, FRAME_MAX, '1);
    // Remap an existing page, then rewrite its flags (high flag bits go in unmasked).
    issue_command(CMD_MAP, '1, 40'h12_3456_789A, '0);
    issue_command(CMD_SET_FLAGS, '1, FRAME_W'($urandom), 64'h8000_0000_0000_0006);
    issue_command(CMD_SET_FLAGS, '1, FRAME_W'($urandom), '0);
    // Unmap, then both commands on the now empty leaf.
    issue_command(CMD_UNMAP, make_vp(0, 0, 0, 0), FRAME_MAX, '0);
    issue_command(CMD_UNMAP, make_vp(0, 0, 0, 0), '0, '0);
    issue_command(CMD_SET_FLAGS, make_vp(0, 0, 0, 0), '0, 64'h7);
    // Share upper levels: one new table, then two.
    issue_command(CMD_MAP, make_vp(0, 0, 5, 7), 40'h1, 64'h2);
    issue_command(CMD_MAP, make_vp(0, 9, 1, 2), 40'h2, 64'h4);
    // Use up the pool: three, three, then one more before it runs dry mid-walk.
    issue_command(CMD_MAP, make_vp(1, 2, 3, 4), 40'h3, '0);
    issue_command(CMD_MAP, make_vp(2, 0, 0, 0), 40'h4, '0);
    issue_command(CMD_MAP, make_vp(3, 0, 0, 0), 40'h5, '0);
    // The link made before exhaustion stays; walks through it still fail.
    issue_command(CMD_MAP, make_vp(3, 1, 1, 1), 40'h6, '0);
    issue_command(CMD_UNMAP, make_vp(3, 0, 0, 0), '0, '0);
    // Existing tables still take new leaves with the pool empty.
    issue_command(CMD_MAP, make_vp(0, 0, 5, 8), FRAME_MAX, 64'hFFF);
    issue_command(CMD_SET_FLAGS, make_vp(0, 0, 5, 7), '0, {$urandom, $urandom});
    issue_command(CMD_UNMAP, make_vp(0, 9, 1, 2), '0, '0);
    issue_command(CMD_MAP, make_vp(0, 9, 1, 2), FRAME_W'($urandom), 64'h10);

    // Phase 0: slow receiver.
    send_random_commands(200);
    drain_results();

    // Phase 1: slow sender. Moving the base turns links into dangling or aliased ones.
    set_idling(71, 36);
    write_pool_base('0);
    send_random_commands(100);
    drain_results();
    write_pool_base(FRAME_W'({$urandom, $urandom}));
    send_random_commands(100);
    drain_results();

    // Phase 2: no idling, original base so the old walks are live again; the hold
    // stretch runs at its start.
    set_idling(0, 0);
    write_pool_base(FRAME_MAX);
    phase <= 2;
    send_random_commands(200);
    drain_results();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/fltpu_pkg.sv
design/fltpu_dpath.sv
design/fltpu_ctrl.sv
design/four_level_page_table_updater.sv
design/fltpu_checker.sv
verif/pt_walk_checker.sv
verif/tb_four_level_page_table_updater.sv
